@@ sv/text_console_writer_top_macros.svh @@
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_WRITER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ctw_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console writer package
// Item types, operation codes and default geometry of the console.
// ----------------------------------------------------------------------------
package ctw_pkg;

  localparam int ROWS_DEFAULT = 25;
  localparam int COLS_DEFAULT = 80;

  localparam logic [7:0] NEWLINE_CODE     = 8'd10;
  localparam logic [7:0] SPACE_CODE       = 8'd32;
  localparam logic [7:0] CLEAR_ATTR_RESET = 8'd15;

  localparam logic [2:0] KIND_PUT    = 3'd0;
  localparam logic [2:0] KIND_MOVE   = 3'd1;
  localparam logic [2:0] KIND_CLEAR  = 3'd2;
  localparam logic [2:0] KIND_SCROLL = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] char_code;
    logic [7:0] color;
    logic [4:0] target_row;
    logic [6:0] target_col;
    logic [7:0] scroll_count;
  } in_item_t;

  typedef struct packed {
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
  } out_item_t;

endpackage

@@ sv/text_console_writer_top.sv @@
// ----------------------------------------------------------------------------
// Text console writer
// Character grid with cursor: put, move, clear, scroll and cell read.
// ----------------------------------------------------------------------------
// A command is transferred at a rising edge where start is high and busy is
// low, and its result appears on out_data for exactly one cycle, flagged by
// out_valid, in the cycle right after the transfer; the receiver cannot stall,
// so it must take every result in that cycle. Put character, move cursor and
// read cell may follow each other back to back unless a put scrolls. Clear
// holds busy while it writes every cell, and scroll holds it while it copies
// the grid through the single read port and the single write port of the
// cell RAM, one cell per cycle. A put that runs past the last cell, or a
// newline on the bottom row, starts a one-row scroll. After reset the block
// zeroes the cell RAM with busy high; configuration writes are taken at any
// time and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module text_console_writer_top #(
  parameter int ROWS = ctw_pkg::ROWS_DEFAULT,
  parameter int COLS = ctw_pkg::COLS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ctw_pkg::in_item_t  in_data,
  output logic               out_valid,
  output ctw_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);

  import ctw_pkg::*;

  // Cells are addressed as {row, column}, so a row occupies a power-of-two
  // stride and no multiplier is needed. Columns at or beyond COLS are never
  // touched.
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = ROWS * (1 << CW);

  // Sequencer states.
  localparam logic [1:0] ST_INIT   = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_CLEAR  = 2'd2;
  localparam logic [1:0] ST_SCROLL = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [RW-1:0] row_cnt_r, row_cnt_nxt;
  logic [CW-1:0] col_cnt_r, col_cnt_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic          wr_pend_r, wr_pend_nxt;
  logic [AW-1:0] wr_addr_r, wr_addr_nxt;
  logic          wr_zero_r, wr_zero_nxt;
  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [7:0]    clear_attr_r;
  logic          out_valid_r;
  logic          rd_pend_r, rd_pend_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  logic          accept;
  logic          sweep_col_last;
  logic          sweep_last;
  logic [8:0]    src_row;
  logic          src_ok;
  logic [RW:0]   row_inc;
  logic          wrap_row;
  logic          trow_ok;
  logic          tcol_ok;

  // A scroll still has one cell write in flight after its last read.
  assign busy   = (state_r != ST_IDLE) || wr_pend_r;
  assign accept = start && !busy;

  assign sweep_col_last = (col_cnt_r == CW'(COLS - 1));
  assign sweep_last     = sweep_col_last && (row_cnt_r == RW'(ROWS - 1));

  // Scroll source row for the destination row being written; rows beyond the
  // grid supply zero cells.
  assign src_row = 9'(row_cnt_r) + 9'(shift_r);
  assign src_ok  = (src_row < 9'(ROWS));

  assign row_inc = {1'b0, cur_row_r} + {{RW{1'b0}}, 1'b1};
  assign trow_ok = ({2'b00, in_data.target_row} < 7'(ROWS));
  assign tcol_ok = ({1'b0, in_data.target_col} < 8'(COLS));

  always_comb begin
    state_nxt   = state_r;
    row_cnt_nxt = row_cnt_r;
    col_cnt_nxt = col_cnt_r;
    shift_nxt   = shift_r;
    wr_pend_nxt = 1'b0;
    wr_addr_nxt = wr_addr_r;
    wr_zero_nxt = wr_zero_r;
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    rd_pend_nxt = 1'b0;
    wrap_row    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = {cur_row_r, cur_col_r};
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = {row_cnt_r, col_cnt_r};

    // Shared cell counter for the init, clear and scroll sweeps.
    if (state_r != ST_IDLE) begin
      if (sweep_last) begin
        row_cnt_nxt = '0;
        col_cnt_nxt = '0;
        state_nxt   = ST_IDLE;
      end else if (sweep_col_last) begin
        row_cnt_nxt = row_cnt_r + RW'(1);
        col_cnt_nxt = '0;
      end else begin
        col_cnt_nxt = col_cnt_r + CW'(1);
      end
    end

    unique case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = {row_cnt_r, col_cnt_r};
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = {row_cnt_r, col_cnt_r};
        ram_wdata = {clear_attr_r, SPACE_CODE};
      end
      ST_SCROLL: begin
        // Read the source cell now and write the destination next cycle.
        // Sources always lie below the destinations already written, at higher addresses.
        ram_re      = src_ok;
        ram_raddr   = {src_row[RW-1:0], col_cnt_r};
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = {row_cnt_r, col_cnt_r};
        wr_zero_nxt = !src_ok;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data.kind)
            KIND_PUT: begin
              if (in_data.char_code == NEWLINE_CODE) begin
                wrap_row = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = {in_data.color, in_data.char_code};
                wrap_row  = (cur_col_r == CW'(COLS - 1));
                cur_col_nxt = cur_col_r + CW'(1);
              end
              if (wrap_row) begin
                cur_col_nxt = '0;
                if (row_inc == (RW + 1)'(ROWS)) begin
                  // Ran off the bottom: cursor stays on the last row and the
                  // grid moves up one row.
                  shift_nxt = 8'd1;
                  state_nxt = ST_SCROLL;
                end else begin
                  cur_row_nxt = row_inc[RW-1:0];
                end
              end
            end
            KIND_MOVE: begin
              cur_row_nxt = trow_ok ? RW'(in_data.target_row) : RW'(ROWS - 1);
              cur_col_nxt = tcol_ok ? CW'(in_data.target_col) : CW'(COLS - 1);
            end
            KIND_CLEAR: begin
              cur_row_nxt = '0;
              cur_col_nxt = '0;
              state_nxt   = ST_CLEAR;
            end
            KIND_SCROLL: begin
              if (in_data.scroll_count != 8'd0) begin
                shift_nxt = in_data.scroll_count;
                state_nxt = ST_SCROLL;
              end
              if (in_data.scroll_count >= 8'(cur_row_r)) begin
                cur_row_nxt = '0;
              end else begin
                cur_row_nxt = cur_row_r - RW'(in_data.scroll_count);
              end
            end
            KIND_READ: begin
              // Out-of-range reads report zero cell bytes.
              if (trow_ok && tcol_ok) begin
                ram_re      = 1'b1;
                ram_raddr   = {RW'(in_data.target_row), CW'(in_data.target_col)};
                rd_pend_nxt = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
    endcase

    // Write-back stage of the scroll copy.
    if (wr_pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = wr_addr_r;
      ram_wdata = wr_zero_r ? 16'd0 : ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      row_cnt_r    <= '0;
      col_cnt_r    <= '0;
      wr_pend_r    <= 1'b0;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      clear_attr_r <= CLEAR_ATTR_RESET;
      out_valid_r  <= 1'b0;
      rd_pend_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_cnt_r   <= row_cnt_nxt;
      col_cnt_r   <= col_cnt_nxt;
      wr_pend_r   <= wr_pend_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      out_valid_r <= accept;
      rd_pend_r   <= rd_pend_nxt;
      if (cfg_we) begin
        clear_attr_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    shift_r   <= shift_nxt;
    wr_addr_r <= wr_addr_nxt;
    wr_zero_r <= wr_zero_nxt;
  end

  ctw_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The cursor registers already hold the post-command cursor during the
  // result cycle; the cell bytes come straight from the RAM read register.
  assign out_valid           = out_valid_r;
  assign out_data.cursor_row = 5'(cur_row_r);
  assign out_data.cursor_col = 7'(cur_col_r);
  assign out_data.cell_char  = rd_pend_r ? ram_rdata[7:0]  : 8'd0;
  assign out_data.cell_attr  = rd_pend_r ? ram_rdata[15:8] : 8'd0;

`include "text_console_writer_top_macros.svh"

  `CTW_ASSERT_NEXT(a_result_follows, accept, out_valid, "command transfer without result")
  `CTW_ASSERT_NOW(a_cursor_in_grid, out_valid,
                  (32'(cur_row_r) < ROWS) && (32'(cur_col_r) < COLS), "cursor outside grid")
  `CTW_ASSERT_NOW(a_scroll_no_overlap, (state_r == ST_SCROLL) && wr_pend_r && ram_re,
                  ram_waddr != ram_raddr, "scroll reads a cell it is writing")
  `CTW_ASSERT_NOW(a_pend_from_scroll, wr_pend_r, $past(state_r) == ST_SCROLL,
                  "cell write-back outside a scroll")

endmodule

@@ sv/ctw_ram.sv @@
// ----------------------------------------------------------------------------
// Text console writer RAM
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ctw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives console commands through the start/busy port and checks every
// cursor report against a cycle-free model of the character grid, with
// directed corner cases first and then long runs of random text traffic.
// ----------------------------------------------------------------------------
module tb;
  import ctw_pkg::*;

  // Geometry of the instance under test; the model uses the same values.
  localparam int ROWS  = ROWS_DEFAULT;
  localparam int COLS  = COLS_DEFAULT;
  localparam int CELLS = ROWS * COLS;

  // Kinds 5 to 7 carry no operation; the block must only report the cursor.
  localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

  localparam int RESET_CYCLES   = 7;
  localparam int MAX_GAP        = 19;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int RANDOM_PHASES  = 5;
  // The result arrives in the cycle after its transfer, so a short settle is enough.
  localparam int SETTLE_CYCLES  = 16;
  // The slowest legal run has every item start a full grid copy (one grid
  // walk each) plus the longest sender gap and the clearing pass after
  // reset; the limit is several times that.
  localparam int LIMIT_CYCLES   = 10_000_000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_item_t   in_data;
  logic       out_valid;
  out_item_t  out_data;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  // Model of the console: the cell grid ({attribute, character}), the cursor
  // and the attribute used by clear.
  logic [15:0] grid_model [CELLS];
  int unsigned row_model;
  int unsigned col_model;
  logic [7:0]  clear_attr_model;

  // Cursor reports predicted for accepted commands, oldest first.
  out_item_t pending_reports [$];

  int fail_count  = 0;
  int cycle_count = 0;
  // Number of upcoming commands that are sent with no idle cycles at all.
  int burst_left  = 0;

  always #6 clk = ~clk;

  text_console_writer_top #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Console model
  // --------------------------------------------------------------------------

  // Moves the whole grid up by a number of rows. Rows that come in at the
  // bottom are zero, and a count of ROWS or more leaves nothing but zeros.
  function automatic void shift_grid_up(input int unsigned rows_up);
    for (int i = 0; i < CELLS; i++) begin
      if (rows_up < ROWS && i + rows_up * COLS < CELLS) begin
        grid_model[i] = grid_model[i + rows_up * COLS];
      end else begin
        grid_model[i] = 16'h0000;
      end
    end
  endfunction

  // Applies one command to the model and returns the report it must cause.
  function automatic out_item_t console_apply(input in_item_t cmd);
    out_item_t rep;
    int unsigned cell_idx;
    rep = '0;
    case (cmd.kind)
      KIND_PUT: begin
        if (cmd.char_code == NEWLINE_CODE) begin
          row_model++;
          col_model = 0;
        end else begin
          grid_model[row_model * COLS + col_model] = {cmd.color, cmd.char_code};
          col_model++;
          if (col_model >= COLS) begin
            col_model = 0;
            row_model++;
          end
        end
        // Running off the bottom scrolls one row and keeps the cursor on
        // the last row.
        if (row_model >= ROWS) begin
          shift_grid_up(1);
          row_model = ROWS - 1;
        end
      end
      KIND_MOVE: begin
        row_model = (cmd.target_row < ROWS) ? int'(cmd.target_row) : ROWS - 1;
        col_model = (cmd.target_col < COLS) ? int'(cmd.target_col) : COLS - 1;
      end
      KIND_CLEAR: begin
        for (int i = 0; i < CELLS; i++) grid_model[i] = {clear_attr_model, SPACE_CODE};
        row_model = 0;
        col_model = 0;
      end
      KIND_SCROLL: begin
        shift_grid_up(cmd.scroll_count);
        row_model = (cmd.scroll_count >= row_model) ? 0 : row_model - cmd.scroll_count;
      end
      KIND_READ: begin
        if (cmd.target_row < ROWS && cmd.target_col < COLS) begin
          cell_idx = cmd.target_row * COLS + cmd.target_col;
          rep.cell_char = grid_model[cell_idx][7:0];
          rep.cell_attr = grid_model[cell_idx][15:8];
        end
      end
      default: begin
      end
    endcase
    rep.cursor_row = 5'(row_model);
    rep.cursor_col = 7'(col_model);
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Command construction
  // --------------------------------------------------------------------------

  function automatic in_item_t command(input logic [2:0] kind, input logic [7:0] ch,
                                       input logic [7:0] color, input logic [4:0] row,
                                       input logic [6:0] col, input logic [7:0] count);
    in_item_t cmd;
    cmd.kind         = kind;
    cmd.char_code    = ch;
    cmd.color        = color;
    cmd.target_row   = row;
    cmd.target_col   = col;
    cmd.scroll_count = count;
    return cmd;
  endfunction

  // Random traffic is mostly lines of text with the odd newline, so the
  // cursor walks the grid, wraps and scrolls the bottom row often. Moves and
  // reads keep the cursor and the cell contents interesting; the fields a
  // kind does not use carry random noise so every input bit toggles.
  function automatic in_item_t random_command();
    in_item_t    cmd;
    int unsigned pick;
    cmd.char_code    = 8'($urandom());
    cmd.color        = 8'($urandom());
    cmd.target_row   = 5'($urandom());
    cmd.target_col   = 7'($urandom());
    cmd.scroll_count = 8'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      cmd.kind = KIND_PUT;
      case ($urandom_range(0, 19))
        0:       cmd.char_code = NEWLINE_CODE;
        1:       ;  // keep the full random byte, control codes included
        default: cmd.char_code = 8'($urandom_range(32, 126));
      endcase
    end else if (pick < 74) begin
      cmd.kind = KIND_MOVE;
      if ($urandom_range(0, 3) != 0) begin
        cmd.target_row = 5'($urandom_range(0, ROWS - 1));
        cmd.target_col = 7'($urandom_range(0, COLS - 1));
      end
    end else if (pick < 91) begin
      cmd.kind = KIND_READ;
      case ($urandom_range(0, 2))
        // The row under the cursor is where fresh text usually sits.
        0: begin
          cmd.target_row = 5'(row_model);
          cmd.target_col = 7'($urandom_range(0, COLS - 1));
        end
        1: begin
          cmd.target_row = 5'($urandom_range(0, ROWS - 1));
          cmd.target_col = 7'($urandom_range(0, COLS - 1));
        end
        default: ;  // full-width coordinates, often outside the grid
      endcase
    end else if (pick < 94) begin
      cmd.kind = KIND_SCROLL;
      if ($urandom_range(0, 4) != 0) cmd.scroll_count = 8'($urandom_range(0, 3));
    end else if (pick < 96) begin
      cmd.kind = KIND_CLEAR;
    end else begin
      cmd.kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
    end
    return cmd;
  endfunction

  // --------------------------------------------------------------------------
  // Port activity
  // --------------------------------------------------------------------------

  // Presents one command after a random idle gap and holds it until the
  // transfer, then records the report it must produce. A zero gap keeps start
  // high straight from the previous transfer, so commands go back to back.
  task automatic send_command(input in_item_t cmd);
    int unsigned gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (busy !== 1'b0);
    pending_reports.push_back(console_apply(cmd));
  endtask

  // Waits until every report has come back and the block has finished any
  // grid walk that is still running behind the last report.
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // The attribute register is only written while nothing is in flight.
  task automatic write_clear_attr(input logic [7:0] value);
    wait_idle();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    clear_attr_model = value;
  endtask

  // --------------------------------------------------------------------------
  // Report checking
  // --------------------------------------------------------------------------

  // Every strobed report is compared with the oldest prediction. The block
  // cannot be held off, so every strobe is a transfer.
  always @(posedge clk) begin : check_reports
    out_item_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $error("report with no command outstanding: row %0d col %0d",
               out_data.cursor_row, out_data.cursor_col);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (out_data.cursor_row !== want.cursor_row) begin
          $error("cursor_row: expected %0d, got %0d", want.cursor_row, out_data.cursor_row);
          fail_count++;
        end
        if (out_data.cursor_col !== want.cursor_col) begin
          $error("cursor_col: expected %0d, got %0d", want.cursor_col, out_data.cursor_col);
          fail_count++;
        end
        if (out_data.cell_char !== want.cell_char) begin
          $error("cell_char: expected 0x%02h, got 0x%02h", want.cell_char, out_data.cell_char);
          fail_count++;
        end
        if (out_data.cell_attr !== want.cell_attr) begin
          $error("cell_attr: expected 0x%02h, got 0x%02h", want.cell_attr, out_data.cell_attr);
          fail_count++;
        end
      end
    end
  end

  // A hung handshake or a lost report ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // The grid is zero after reset, reads outside the grid return zero, and
  // spare kinds only echo the cursor.
  task automatic test_reset_state();
    send_command(command(KIND_READ, 8'h00, 8'h00, 5'd0, 7'd0, 8'h00));
    send_command(command(KIND_READ, 8'h00, 8'h00, 5'(ROWS), 7'd0, 8'h00));
    send_command(command(KIND_READ, 8'h00, 8'h00, 5'd31, 7'd127, 8'h00));
    send_command(command(KIND_SPARE_FIRST, 8'hFF, 8'hFF, 5'd31, 7'd127, 8'hFF));
    send_command(command(KIND_SPARE_LAST, 8'hFF, 8'hFF, 5'd31, 7'd127, 8'hFF));
  endtask

  // Extreme character and color bytes, a newline, then a put in the last
  // cell that runs past the end of the grid and a newline on the bottom row,
  // both of which scroll one row.
  task automatic test_put_and_wrap();
    send_command(command(KIND_PUT, 8'hFF, 8'hFF, 5'd0, 7'd0, 8'h00));
    send_command(command(KIND_PUT, 8'h00, 8'h00, 5'd0, 7'd0, 8'h00));
    send_command(command(KIND_PUT, NEWLINE_CODE, 8'h00, 5'd0, 7'd0, 8'h00));
    send_command(command(KIND_READ, 8'h00, 8'h00, 5'd0, 7'd1, 8'h00));
    // A move beyond both edges saturates to the last cell.
    send_command(command(KIND_MOVE, 8'h00, 8'h00, 5'd31, 7'd127, 8'h00));
    send_command(command(KIND_PUT, 8'h5A, 8'h1E, 5'd0, 7'd0, 8'h00));
    send_command(command(KIND_READ, 8'h00, 8'h00, 5'(ROWS - 2), 7'(COLS - 1), 8'h00));
    send_command(command(KIND_PUT, NEWLINE_CODE, 8'h00, 5'd0, 7'd0, 8'h00));
  endtask

  // Clear fills the grid with spaces in the programmed attribute; both
  // extreme attribute values are used.
  task automatic test_clear_attribute();
    write_clear_attr(8'h00);
    send_command(command(KIND_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0, 8'h00));
    send_command(command(KIND_READ, 8'h00, 8'h00, 5'd12, 7'd40, 8'h00));
    write_clear_attr(8'hFF);
    send_command(command(KIND_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0, 8'h00));
    send_command(command(KIND_READ, 8'h00, 8'h00, 5'(ROWS - 1), 7'(COLS - 1), 8'h00));
  endtask

  // Scroll by zero, by a few rows, by enough to push the cursor row below
  // zero (it saturates), and by far more than the grid holds.
  task automatic test_scroll();
    send_command(command(KIND_MOVE, 8'h00, 8'h00, 5'd10, 7'd5, 8'h00));
    send_command(command(KIND_PUT, 8'h61, 8'h4C, 5'd0, 7'd0, 8'h00));
    send_command(command(KIND_SCROLL, 8'h00, 8'h00, 5'd0, 7'd0, 8'd0));
    send_command(command(KIND_SCROLL, 8'h00, 8'h00, 5'd0, 7'd0, 8'd3));
    send_command(command(KIND_READ, 8'h00, 8'h00, 5'd7, 7'd5, 8'h00));
    send_command(command(KIND_SCROLL, 8'h00, 8'h00, 5'd0, 7'd0, 8'(ROWS - 1)));
    send_command(command(KIND_SCROLL, 8'h00, 8'h00, 5'd0, 7'd0, 8'hFF));
    send_command(command(KIND_READ, 8'h00, 8'h00, 5'd0, 7'd0, 8'h00));
  endtask

  // Phases of random traffic, each under a fresh clear attribute.
  task automatic test_random_traffic();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_clear_attr(8'($urandom()));
      for (int n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++) send_command(random_command());
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    for (int i = 0; i < CELLS; i++) grid_model[i] = 16'h0000;
    row_model        = 0;
    col_model        = 0;
    clear_attr_model = CLEAR_ATTR_RESET;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    // The block zeroes its cell RAM after reset with busy high.
    wait_idle();

    test_reset_state();
    test_put_and_wrap();
    test_clear_attribute();
    test_scroll();
    test_random_traffic();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d reports never arrived", pending_reports.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/ctw_pkg.sv
sv/ctw_ram.sv
sv/text_console_writer_top.sv
tb/sv/tb.sv
